// ===== src/mbox_from_line_escaper_defines.svh =====
// Assertion macros used by the checker file mbfe_checker.sv.
`ifndef MBOX_FROM_LINE_ESCAPER_DEFINES_SVH
`define MBOX_FROM_LINE_ESCAPER_DEFINES_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define MBFE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mbfe check failed");

// Next-cycle implication, sampled on clock, quiet during reset.
`define MBFE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mbfe check failed");

`endif

// ===== src/mbfe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbfe_pkg
// Types, character codes and the "From " lookup for the From-line escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package mbfe_pkg;

   localparam int RUN_DEPTH = 6;

   localparam logic [7:0] CH_QUOTE   = 8'h3E;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [2:0] WORD_LAST  = 3'd4;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] run_count_type;

   typedef struct packed {
      logic       scanning;
      logic [2:0] match_length;
   } scan_state_type;

   // Byte of "From " at a given position; position 4 is the space.
   function automatic byte_type from_char(input logic [2:0] pos);
      byte_type c;
      case (pos)
         3'd0:    c = 8'h46;
         3'd1:    c = 8'h72;
         3'd2:    c = 8'h6F;
         3'd3:    c = 8'h6D;
         default: c = 8'h20;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/mbfe_scan.sv =====
// ----------------------------------------------------------------------------
// mbfe_scan
// Line scanner: works out the output run and next scan state for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfe_scan
   import mbfe_pkg::*;
(
   input  wire byte_type       data_byte,
   input  wire logic           first_of_message,
   input  wire logic           exempt_first_line,
   input  wire logic           last_of_message,
   input  wire scan_state_type state_ff,
   output scan_state_type      state_in,
   output byte_type            run_bytes [RUN_DEPTH],
   output run_count_type       run_count
);

   logic       scan;
   logic [2:0] m;
   logic       is_quote;
   logic       matches_word;
   logic       lead;
   logic [2:0] held_count;
   logic       has_tail;

   always_comb begin
      scan = first_of_message ? !exempt_first_line : state_ff.scanning;
      m    = (first_of_message || state_ff.match_length > WORD_LAST) ? 3'd0
                                                                     : state_ff.match_length;
      is_quote     = (data_byte == CH_QUOTE);
      matches_word = (data_byte == from_char(m));

      lead       = 1'b0;
      held_count = 3'd0;
      has_tail   = 1'b1;
      state_in   = '{scanning: 1'b1, match_length: 3'd0};

      if (!scan) begin
         state_in.scanning = (data_byte == CH_NEWLINE);
      end else if (m == 3'd0 && is_quote) begin
         state_in.scanning = 1'b1;
      end else if (matches_word && m < WORD_LAST) begin
         // hold back one more byte of the word
         has_tail              = 1'b0;
         state_in.match_length = m + 3'd1;
         if (last_of_message) begin
            held_count = m + 3'd1;
         end
      end else if (matches_word) begin
         // "From " complete: extra quote, then the whole word
         lead              = 1'b1;
         held_count        = 3'd5;
         has_tail          = 1'b0;
         state_in.scanning = 1'b0;
      end else begin
         held_count        = m;
         state_in.scanning = (data_byte == CH_NEWLINE);
      end

      if (last_of_message) begin
         state_in = '{scanning: 1'b1, match_length: 3'd0};
      end

      run_count = held_count + {2'b00, lead} + {2'b00, has_tail};
   end

   always_comb begin
      logic [2:0] pos;
      logic [2:0] q;
      for (int p = 0; p < RUN_DEPTH; p++) begin
         pos = 3'(p);
         q   = pos - {2'b00, lead};
         if (lead && pos == 3'd0) begin
            run_bytes[p] = CH_QUOTE;
         end else if (q < held_count) begin
            run_bytes[p] = from_char(q);
         end else begin
            run_bytes[p] = data_byte;
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/mbox_from_line_escaper.sv =====
// ----------------------------------------------------------------------------
// mbox_from_line_escaper
// Escapes "From " lines in a message body byte stream, mboxrd style.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-----------------------------------
//  req     | in  | req_valid / req_ready   | data_byte, first_of_message,
//          |     |                         | exempt_first_line, last_of_message
//  rsp     | out | rsp_valid / rsp_ready   | out_byte, last_of_run, message_end
//
//  One byte is taken per cycle while each transaction yields at most one
//  result; a transaction yielding more than one result holds req_ready low
//  while the run register drains. Held bytes of "From" yield none.
//  The next transaction is taken in the cycle the last byte of a run leaves.
//  Reset (synchronous, active high) empties the run register, restarts
//  scanning at line start and drops held bytes.
//  A stalled rsp side holds the run register and so, on its last byte, req.
//
// ----------------------------------------------------------------------------
`default_nettype none

module mbox_from_line_escaper
   import mbfe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire byte_type req_data_byte,
   input  wire logic     req_first_of_message,
   input  wire logic     req_exempt_first_line,
   input  wire logic     req_last_of_message,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output byte_type      rsp_out_byte,
   output logic          rsp_last_of_run,
   output logic          rsp_message_end
);

   // line scanner state
   scan_state_type state_ff;
   scan_state_type state_in;

   // run register: bytes of the current transaction's result, drained in order
   byte_type      run_bytes_ff [RUN_DEPTH];
   byte_type      run_bytes_in [RUN_DEPTH];
   run_count_type count_ff;
   run_count_type count_in;
   run_count_type idx_ff;
   logic          end_ff;

   logic req_fire;
   logic rsp_fire;
   logic at_last;

   mbfe_scan u_scan (
      .data_byte         (req_data_byte),
      .first_of_message  (req_first_of_message),
      .exempt_first_line (req_exempt_first_line),
      .last_of_message   (req_last_of_message),
      .state_ff          (state_ff),
      .state_in          (state_in),
      .run_bytes         (run_bytes_in),
      .run_count         (count_in)
   );

   assign at_last   = (idx_ff == count_ff - 3'd1);
   assign rsp_valid = (count_ff != 3'd0);
   assign req_ready = !rsp_valid || (rsp_ready && at_last);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign rsp_out_byte    = run_bytes_ff[idx_ff];
   assign rsp_last_of_run = at_last;
   assign rsp_message_end = at_last && end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{scanning: 1'b1, match_length: 3'd0};
         count_ff <= 3'd0;
         idx_ff   <= 3'd0;
         end_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            // a fresh run replaces the one whose last byte just left
            state_ff <= state_in;
            count_ff <= count_in;
            idx_ff   <= 3'd0;
            end_ff   <= req_last_of_message;
         end else if (rsp_fire) begin
            if (at_last) begin
               count_ff <= 3'd0;
               idx_ff   <= 3'd0;
            end else begin
               idx_ff <= idx_ff + 3'd1;
            end
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         run_bytes_ff <= run_bytes_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/mbfe_checker.sv =====
// ----------------------------------------------------------------------------
// mbfe_checker
// Port-level checks on the From-line escaper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mbox_from_line_escaper_defines.svh"

module mbfe_checker
   import mbfe_pkg::*;
(
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     req_ready,
   input wire logic     rsp_valid,
   input wire logic     rsp_ready,
   input wire byte_type rsp_out_byte,
   input wire logic     rsp_last_of_run,
   input wire logic     rsp_message_end
);

   // message end only on the closing byte of a run
   `MBFE_ASSERT_NOW(a_end_on_run_last, rsp_valid && rsp_message_end, rsp_last_of_run)

   // mid-run results block new transactions
   `MBFE_ASSERT_NOW(a_run_blocks_req, rsp_valid && !rsp_last_of_run, !req_ready)

   // taking a mid-run byte leaves more of the run to come
   `MBFE_ASSERT_NEXT(a_run_continues, rsp_valid && rsp_ready && !rsp_last_of_run, rsp_valid)

   // stalled result holds
   `MBFE_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run))

endmodule

bind mbox_from_line_escaper mbfe_checker u_mbfe_checker (.*);

`default_nettype wire
